[design/hsl2rgb_pkg.sv]
// Shared types for the HSL-to-RGB pixel converter.
// Pixel structs and the hue sextant codes; no dependencies.
package hsl2rgb_pkg;

	typedef struct packed {
		logic [7:0] hue;
		logic [7:0] saturation;
		logic [7:0] lightness;
	} hsl_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// Hue sextant: upper bits of hue*6
	typedef enum logic [2:0] {
		SEXT_RED_YEL  = 3'd0,
		SEXT_YEL_GRN  = 3'd1,
		SEXT_GRN_CYN  = 3'd2,
		SEXT_CYN_BLU  = 3'd3,
		SEXT_BLU_MAG  = 3'd4,
		SEXT_MAG_RED  = 3'd5
	} sextant_t;

endpackage

[design/hsl_to_rgb_converter.sv]
// Top level of the HSL-to-RGB pixel converter: three-stage pipeline.
// Depends on hsl2rgb_pkg for the pixel structs and sextant codes.
//
// Usage
//   Input channel pix: pix_valid / pix_stall / pix (hue, saturation, lightness).
//   Output channel rgb: rgb_valid / rgb_stall / rgb (red, green, blue).
//   A transaction completes on a rising clk edge with valid high and stall low.
//   Every input transaction yields exactly one output transaction, in order.
//
// Stages and throughput
//   An accepted input passes the stage 1, 2 and 3 registers to rgb. One pixel
//   per clock is sustained while rgb_stall is low. Stage 1 forms chroma with
//   an 9x8 multiply and hue*6, stage 2 forms the secondary component with a
//   second 9x8 multiply and the offset m, stage 3 routes by sextant and adds
//   m into the output register. The multipliers set the per-stage depth.
//
// Reset and back-pressure
//   arst_n clears all stage valid bits asynchronously; payload is not reset.
//   When the receiver stalls, the output holds; earlier stages keep filling
//   empty slots, so up to three pixels are buffered before pix_stall rises.
//   pix_stall depends combinationally on rgb_stall and the stage valid bits.
//   Zero lightness gives black regardless of hue and saturation.
module hsl_to_rgb_converter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pix_valid,
	output logic                pix_stall,
	input  hsl2rgb_pkg::hsl_t   pix,
	output logic                rgb_valid,
	input  logic                rgb_stall,
	output hsl2rgb_pkg::rgb_t   rgb
);

	// stage valid bits and advance enables
	logic v_s1, v_s2, v_s3;
	logic adv1, adv2, adv3;

	// a stage moves when its successor is empty or moving
	assign adv3      = !v_s3 || !rgb_stall;
	assign adv2      = !v_s2 || adv3;
	assign adv1      = !v_s1 || adv2;
	assign pix_stall = !adv1;
	assign rgb_valid = v_s3;

	// ---------------- stage 1: chroma and hue*6 ----------------
	logic [8:0]  l1;
	logic [9:0]  dbl_l1;
	logic [9:0]  far_l1;
	logic [8:0]  c_fac;
	logic [16:0] c_prod;
	logic [10:0] hh;

	logic [7:0]  c_s1;
	logic [10:0] hh_s1;
	logic [7:0]  l_s1;

	always_comb begin
		l1     = {1'b0, pix.lightness} + 9'd1;
		dbl_l1 = {l1, 1'b0};
		far_l1 = 10'd512 - dbl_l1;
		// dark half uses 2*(l+1), light half 512-2*(l+1); both fit 9 bits
		if (!pix.lightness[7]) begin
			c_fac = dbl_l1[8:0];
		end else begin
			c_fac = far_l1[8:0];
		end
		c_prod = {8'd0, c_fac} * {9'd0, pix.saturation};
		hh     = {1'b0, pix.hue, 2'b00} + {2'b00, pix.hue, 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && pix_valid) begin
			c_s1  <= c_prod[15:8];
			hh_s1 <= hh;
			l_s1  <= pix.lightness;
		end
	end

	// ---------------- stage 2: secondary component and offset ----------------
	logic [8:0]  mix;
	logic [8:0]  x_fac;
	logic [16:0] x_prod;
	logic [7:0]  m_val;

	logic [7:0]            c_s2;
	logic [7:0]            x_s2;
	logic [7:0]            m_s2;
	hsl2rgb_pkg::sextant_t sext_s2;
	logic                  black_s2;

	always_comb begin
		mix = {1'b0, hh_s1[7:0]} + 9'd1;
		// odd sextants ramp down
		if (hh_s1[8]) begin
			x_fac = 9'd256 - mix;
		end else begin
			x_fac = mix;
		end
		x_prod = {8'd0, x_fac} * {9'd0, c_s1};
		m_val  = l_s1 - {1'b0, c_s1[7:1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			c_s2     <= c_s1;
			x_s2     <= x_prod[15:8];
			m_s2     <= m_val;
			sext_s2  <= hsl2rgb_pkg::sextant_t'(hh_s1[10:8]);
			black_s2 <= (l_s1 == 8'd0);
		end
	end

	// ---------------- stage 3: channel routing and offset add ----------------
	logic [7:0]        r_pre, g_pre, b_pre;
	hsl2rgb_pkg::rgb_t rgb_nxt;

	always_comb begin
		unique case (sext_s2)
			hsl2rgb_pkg::SEXT_RED_YEL: begin
				r_pre = c_s2; g_pre = x_s2; b_pre = 8'd0;
			end
			hsl2rgb_pkg::SEXT_YEL_GRN: begin
				r_pre = x_s2; g_pre = c_s2; b_pre = 8'd0;
			end
			hsl2rgb_pkg::SEXT_GRN_CYN: begin
				r_pre = 8'd0; g_pre = c_s2; b_pre = x_s2;
			end
			hsl2rgb_pkg::SEXT_CYN_BLU: begin
				r_pre = 8'd0; g_pre = x_s2; b_pre = c_s2;
			end
			hsl2rgb_pkg::SEXT_BLU_MAG: begin
				r_pre = x_s2; g_pre = 8'd0; b_pre = c_s2;
			end
			default: begin
				r_pre = c_s2; g_pre = 8'd0; b_pre = x_s2;
			end
		endcase
		if (black_s2) begin
			rgb_nxt = '0;
		end else begin
			rgb_nxt.red   = r_pre + m_s2;
			rgb_nxt.green = g_pre + m_s2;
			rgb_nxt.blue  = b_pre + m_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			rgb <= rgb_nxt;
		end
	end

`ifndef NO_ASSERTIONS
	// a free output means every stage moves, so input never stalls
	a_no_stall_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!rgb_stall |-> !pix_stall)
		else $error("pix_stall high while output side is free");

	// input stalls only when all three stages are full and the output is held
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> (v_s1 && v_s2 && v_s3 && rgb_stall))
		else $error("pix_stall high with room in the pipeline");

	// chroma plus offset never wraps
	a_no_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (({1'b0, c_s2} + {1'b0, m_s2}) <= 9'd255))
		else $error("chroma plus offset exceeds 8 bits");

	// secondary component never exceeds chroma
	a_x_le_c: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (x_s2 <= c_s2))
		else $error("secondary component above chroma");

	// held output stays put while the receiver stalls
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && rgb_stall) |=> (v_s3 && $stable(rgb)))
		else $error("output changed under stall");
`endif

endmodule

[verif/hsl_to_rgb_converter_test.sv]
// Self-checking testbench for the HSL-to-RGB pixel converter.
// Depends on hsl2rgb_pkg (pixel structs, sextant codes) and the converter RTL.
module hsl_to_rgb_converter_test;
	timeunit 1ns;
	timeprecision 1ps;

	// Stall behaviors that the output side cycles through
	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_HALF,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	localparam int LONG_HOLD_CYCLES = 80;
	localparam int MAX_PRINTED_MISMATCHES = 20;

	// One queued expectation: the pixel that went in and the color due out
	typedef struct {
		hsl2rgb_pkg::hsl_t pixel;
		hsl2rgb_pkg::rgb_t color;
	} pending_color_t;

	// Expected colors in arrival order, with the mismatch count
	class pixel_scoreboard;
		pending_color_t due_colors[$];
		int unsigned errors;
		int unsigned checked;
		int unsigned black_count;

		// Integer HSL to RGB at the block's own widths
		function hsl2rgb_pkg::rgb_t convert(hsl2rgb_pkg::hsl_t p);
			logic [9:0]            twice_l1;
			logic [9:0]            span;
			logic [16:0]           chroma_prod;
			logic [16:0]           second_prod;
			logic [10:0]           hue6;
			logic [8:0]            mix;
			logic [7:0]            chroma;
			logic [7:0]            second;
			logic [7:0]            offset;
			hsl2rgb_pkg::sextant_t sext;
			hsl2rgb_pkg::rgb_t     q;
			if (p.lightness == 8'd0)
				return '0;
			twice_l1 = {1'b0, p.lightness, 1'b0} + 10'd2;
			// Chroma rises with lightness up to mid gray, then falls
			span = p.lightness[7] ? 10'd512 - twice_l1 : twice_l1;
			chroma_prod = span * p.saturation;
			chroma = chroma_prod[15:8];
			hue6 = p.hue * 11'd6;
			mix = {1'b0, hue6[7:0]} + 9'd1;
			// Odd sextants ramp down, even ones ramp up
			second_prod = hue6[8] ? (9'd256 - mix) * chroma : mix * chroma;
			second = second_prod[15:8];
			offset = p.lightness - (chroma >> 1);
			sext = hsl2rgb_pkg::sextant_t'(hue6[10:8]);
			case (sext)
				hsl2rgb_pkg::SEXT_RED_YEL: q = '{chroma, second, 8'd0};
				hsl2rgb_pkg::SEXT_YEL_GRN: q = '{second, chroma, 8'd0};
				hsl2rgb_pkg::SEXT_GRN_CYN: q = '{8'd0, chroma, second};
				hsl2rgb_pkg::SEXT_CYN_BLU: q = '{8'd0, second, chroma};
				hsl2rgb_pkg::SEXT_BLU_MAG: q = '{second, 8'd0, chroma};
				default:                   q = '{chroma, 8'd0, second};
			endcase
			q.red   = q.red + offset;
			q.green = q.green + offset;
			q.blue  = q.blue + offset;
			return q;
		endfunction

		task report(string msg);
			if (errors < MAX_PRINTED_MISMATCHES)
				$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		function void note_pixel(hsl2rgb_pkg::hsl_t p);
			pending_color_t e;
			e.pixel = p;
			e.color = convert(p);
			due_colors.push_back(e);
			if (p.lightness == 8'd0)
				black_count++;
		endfunction

		task check_color(hsl2rgb_pkg::rgb_t got);
			pending_color_t e;
			if (due_colors.size() == 0) begin
				report($sformatf("color %h with no pixel pending", got));
				return;
			end
			e = due_colors.pop_front();
			checked++;
			if (got.red !== e.color.red)
				report($sformatf("pixel %h red %h, want %h", e.pixel, got.red, e.color.red));
			if (got.green !== e.color.green)
				report($sformatf("pixel %h green %h, want %h", e.pixel, got.green,
					e.color.green));
			if (got.blue !== e.color.blue)
				report($sformatf("pixel %h blue %h, want %h", e.pixel, got.blue,
					e.color.blue));
		endtask

		function int pending();
			return due_colors.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pix_valid = 1'b0;
	logic pix_stall;
	hsl2rgb_pkg::hsl_t pix = '0;
	logic rgb_valid;
	logic rgb_stall = 1'b0;
	hsl2rgb_pkg::rgb_t rgb;

	pixel_scoreboard sb = new();

	// Output-side stall state
	bit          long_hold_req = 1'b0;
	int          hold_left = 0;
	int          mode_left = 0;
	int          periodic_count = 0;
	int          stall_streak = 0;
	int          longest_hold = 0;
	stall_mode_t stall_mode = STALL_NONE;

	// Hand-picked pixels: all-zero and all-one fields, black with full color,
	// lightness at both sides of mid gray, gray, and hues at every sextant edge
	logic [23:0] corner_pixels [22] = '{
		24'h00_00_00, 24'hFF_FF_FF, 24'hFF_FF_00, 24'h00_FF_01,
		24'h00_FF_7F, 24'h00_FF_80, 24'h00_FF_FF, 24'h55_00_C8,
		24'h2A_FF_80, 24'h2B_FF_80, 24'h55_FF_80, 24'h56_FF_80,
		24'h7F_FF_80, 24'h80_FF_80, 24'hAA_FF_80, 24'hAB_FF_80,
		24'hD5_FF_80, 24'hD6_FF_80, 24'hFF_FF_7F, 24'h15_80_40,
		24'h96_C8_BE, 24'h60_FF_FE
	};

	hsl_to_rgb_converter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.rgb_valid (rgb_valid),
		.rgb_stall (rgb_stall),
		.rgb       (rgb)
	);

	always #4 clk = ~clk;

	// Output side: check every completed transaction, then pick next stall.
	// Values read here are the ones from just before the edge.
	always @(posedge clk) begin
		if (arst_n && rgb_valid && !rgb_stall)
			sb.check_color(rgb);
		stall_streak = rgb_stall ? stall_streak + 1 : 0;
		if (stall_streak > longest_hold)
			longest_hold = stall_streak;
		if (long_hold_req) begin
			hold_left = LONG_HOLD_CYCLES;
			long_hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			// Long hold-off: the pipeline fills and stalls its input
			hold_left--;
			rgb_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 300);
			end
			mode_left--;
			periodic_count++;
			case (stall_mode)
				STALL_NONE:   rgb_stall <= 1'b0;
				STALL_HALF:   rgb_stall <= ($urandom_range(0, 1) != 0);
				STALL_HEAVY:  rgb_stall <= ($urandom_range(0, 4) != 0);
				default:      rgb_stall <= (periodic_count % 5 == 4);
			endcase
		end
	end

	function automatic logic [7:0] edge_value();
		case ($urandom_range(0, 5))
			0:       return 8'd0;
			1:       return 8'd1;
			2:       return 8'd127;
			3:       return 8'd128;
			4:       return 8'd254;
			default: return 8'd255;
		endcase
	endfunction

	// Mostly uniform pixels, with black, edge values and sextant-edge hues mixed in
	function automatic hsl2rgb_pkg::hsl_t random_pixel();
		hsl2rgb_pkg::hsl_t p;
		logic [7:0] hue_edges [12] = '{8'd0, 8'd42, 8'd43, 8'd85, 8'd86, 8'd127,
			8'd128, 8'd170, 8'd171, 8'd213, 8'd214, 8'd255};
		p = hsl2rgb_pkg::hsl_t'(24'($urandom));
		case ($urandom_range(0, 9))
			0: p.lightness = 8'd0;
			1: p = '{edge_value(), edge_value(), edge_value()};
			2: p.hue = hue_edges[$urandom_range(0, 11)];
			default: ;
		endcase
		return p;
	endfunction

	// Offer one pixel and hold it until the transaction completes
	task automatic send_pixel(hsl2rgb_pkg::hsl_t p);
		pix <= p;
		pix_valid <= 1'b1;
		@(posedge clk);
		while (pix_stall)
			@(posedge clk);
		sb.note_pixel(p);
	endtask

	task automatic idle_input(int cycles);
		pix_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Random pixels in bursts of random length, or back to back
	task automatic send_stream(int count, bit back_to_back);
		int burst_left;
		burst_left = $urandom_range(1, 40);
		repeat (count) begin
			send_pixel(random_pixel());
			burst_left--;
			if (!back_to_back && burst_left == 0) begin
				idle_input($urandom_range(1, 8));
				burst_left = $urandom_range(1, 40);
			end
		end
	endtask

	// Stop offering until every expected color has come back
	task automatic drain();
		pix_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corner_pixels[i]) begin
			send_pixel(hsl2rgb_pkg::hsl_t'(corner_pixels[i]));
			if ($urandom_range(0, 2) == 0)
				idle_input($urandom_range(1, 3));
		end
		drain();

		send_stream(400, 1'b0);

		// Hold the output while the input keeps offering
		long_hold_req = 1'b1;
		send_stream(60, 1'b1);
		drain();

		send_stream(600, 1'b1);
		send_stream(540, 1'b0);
		drain();

		// Three-stage pipeline: a few spare cycles catch any stray result
		repeat (12) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d colors never arrived", sb.pending()));

		$display("run: %0d pixels converted and checked, %0d with zero lightness",
			sb.checked, sb.black_count);
		$display("run: output stalled up to %0d cycles in a row with the input backed up",
			longest_hold);
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
